// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked on the clock after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wtba_pkg.sv
// Package with the types, constants and sRGB threshold table of the blend accumulator.
package wtba_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int LUT_SIZE   = 4096;

    localparam int PIXELS    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = $clog2(PIXELS);
    localparam int LUT_BITS  = $clog2(LUT_SIZE);
    localparam int IDX_W     = $clog2(LUT_SIZE + 2);
    localparam int SIZE_W    = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 2;
    localparam int COORD_W   = SIZE_W + 1;
    localparam int Q_W       = 17;
    localparam int DIVSH_W   = 40 + Q_W;

    typedef enum logic
    {
        REQ_ACC  = 1'b0,
        REQ_READ = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        STAT_ACC  = 2'd0,
        STAT_DROP = 2'd1,
        STAT_READ = 2'd2
    } status_t;

    typedef enum logic
    {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_DIV,
        S_ENC,
        S_RESULT
    } state_t;

    typedef struct packed
    {
        logic clear;
        logic load;
        logic check;
        logic fetch;
        logic div;
        logic enc;
    } cmd_t;

    typedef struct packed
    {
        logic drop;
        logic is_read;
        logic clr_last;
        logic step_last;
    } dp_stat_t;

    typedef struct packed
    {
        logic [47:0] sum_r;
        logic [47:0] sum_g;
        logic [47:0] sum_b;
        logic [39:0] sum_w;
    } pix_t;

    typedef logic [IDX_W-1:0] thr_tab_t [256];

    function automatic logic reaches_code(int unsigned idx, int unsigned c);
        logic [255:0] lhs;
        logic [255:0] rhs;
        lhs = 256'd1;
        rhs = 256'd1;
        if (c <= 10)
        begin
            return (64'(idx) * 64'd32946) >= (64'((2 * c - 1) * 5) * 64'(LUT_SIZE));
        end
        for (int k = 0; k < 5; k++)
        begin
            lhs = lhs * 256'(idx);
            rhs = rhs * 256'(LUT_SIZE);
        end
        for (int k = 0; k < 12; k++)
        begin
            lhs = lhs * 256'd10761;
            rhs = rhs * 256'(40 * c + 541);
        end
        return lhs >= rhs;
    endfunction

    function automatic thr_tab_t build_thr();
        thr_tab_t t;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        t[0] = '0;
        for (int unsigned c = 1; c <= 255; c++)
        begin
            lo = 0;
            hi = LUT_SIZE + 1;
            while (lo < hi)
            begin
                mid = lo + ((hi - lo) >> 1);
                if (reaches_code(mid, c))
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 1;
                end
            end
            t[c] = IDX_W'(lo);
        end
        return t;
    endfunction

    localparam thr_tab_t CODE_THR = build_thr();

endpackage

// File: rtl/wtba_ctrl.sv
// Controller state machine that sequences clearing, accumulation and reads.
module wtba_ctrl
    import wtba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t dp_stat,
    output cmd_t     cmd,
    output logic     busy,
    output logic     done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (dp_stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = dp_stat.drop ? S_RESULT : S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = dp_stat.is_read ? S_DIV : S_RESULT;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (dp_stat.step_last)
                begin
                    state_next = S_ENC;
                end
            end
            S_ENC:
            begin
                cmd.enc = 1'b1;
                if (dp_stat.step_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/wtba_datapath.sv
// Datapath with the pixel store, accumulate adders, divider and sRGB encoder.
module wtba_datapath
    import wtba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output dp_stat_t          dp_stat,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [8:0]        cfg_wdata,
    input  logic              req_type,
    input  logic [7:0]        pos_x,
    input  logic [7:0]        pos_y,
    input  logic signed [8:0] origin_x,
    input  logic signed [8:0] origin_y,
    input  logic [8:0]        tile_width,
    input  logic [8:0]        tile_height,
    input  logic [16:0]       blend_weight,
    input  logic [16:0]       lin_red,
    input  logic [16:0]       lin_green,
    input  logic [16:0]       lin_blue,
    output logic [1:0]        status,
    output logic [7:0]        srgb_red,
    output logic [7:0]        srgb_green,
    output logic [7:0]        srgb_blue
);

    logic [8:0]        img_w_reg;
    logic [8:0]        img_h_reg;
    logic              req_reg;
    logic [7:0]        px_reg;
    logic [7:0]        py_reg;
    logic signed [8:0] ox_reg;
    logic signed [8:0] oy_reg;
    logic [8:0]        tw_reg;
    logic [8:0]        th_reg;
    logic [16:0]       wt_reg;
    logic [16:0]       lin_reg [3];
    logic [33:0]       prod_reg [3];
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] clr_reg;
    pix_t              rd_reg;
    pix_t              mem [PIXELS];
    logic [4:0]        step_reg;
    logic [47:0]       rem_reg [3];
    logic [Q_W-1:0]    q_reg [3];
    logic              ov_reg [3];
    logic              wz_reg;
    logic [39:0]       div_reg;
    logic [7:0]        code_reg [3];
    logic [1:0]        status_reg;
    logic [7:0]        out_reg [3];

    logic signed [COORD_W-1:0] x_s;
    logic signed [COORD_W-1:0] y_s;
    logic [SIZE_W-1:0]         ew;
    logic [SIZE_W-1:0]         eh;
    logic                      drop;
    logic [ADDR_W-1:0]         addr;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_wa;
    pix_t                      mem_wd;
    logic [47:0]               sum_in [3];
    logic [48:0]               acc_sum [3];
    logic [40:0]               acc_w;
    logic [DIVSH_W-1:0]        div_sh;
    logic [Q_W-1:0]            v [3];
    logic [Q_W+LUT_BITS-1:0]   idx_full [3];
    logic [IDX_W-1:0]          idx [3];
    logic [7:0]                trial [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= 9'd256;
            img_h_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_WIDTH:  img_w_reg <= cfg_wdata;
                CFG_HEIGHT: img_h_reg <= cfg_wdata;
                default:    img_w_reg <= img_w_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            ox_reg     <= origin_x;
            oy_reg     <= origin_y;
            tw_reg     <= tile_width;
            th_reg     <= tile_height;
            wt_reg     <= blend_weight;
            lin_reg[0] <= lin_red;
            lin_reg[1] <= lin_green;
            lin_reg[2] <= lin_blue;
        end
    end

    always_comb
    begin
        if (req_reg == REQ_ACC)
        begin
            x_s = COORD_W'(ox_reg) + $signed(COORD_W'({1'b0, px_reg}));
            y_s = COORD_W'(oy_reg) + $signed(COORD_W'({1'b0, py_reg}));
        end
        else
        begin
            x_s = $signed(COORD_W'(px_reg));
            y_s = $signed(COORD_W'(py_reg));
        end
        ew = (SIZE_W'(img_w_reg) < SIZE_W'(MAX_WIDTH)) ? SIZE_W'(img_w_reg)
                                                        : SIZE_W'(MAX_WIDTH);
        eh = (SIZE_W'(img_h_reg) < SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(img_h_reg)
                                                         : SIZE_W'(MAX_HEIGHT);
        drop = ((req_reg == REQ_ACC)
                && (({1'b0, px_reg} >= tw_reg) || ({1'b0, py_reg} >= th_reg)))
               || (x_s < 0) || (y_s < 0)
               || (x_s >= $signed({1'b0, ew})) || (y_s >= $signed({1'b0, eh}));
        addr = ADDR_W'(ADDR_W'(y_s) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x_s);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            addr_reg <= addr;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= 34'(lin_reg[i]) * 34'(wt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_comb
    begin
        sum_in[0] = rd_reg.sum_r;
        sum_in[1] = rd_reg.sum_g;
        sum_in[2] = rd_reg.sum_b;
        for (int i = 0; i < 3; i++)
        begin
            acc_sum[i] = {1'b0, sum_in[i]} + 49'(prod_reg[i]);
        end
        acc_w        = {1'b0, rd_reg.sum_w} + 41'(wt_reg);
        mem_wd.sum_r = acc_sum[0][48] ? '1 : acc_sum[0][47:0];
        mem_wd.sum_g = acc_sum[1][48] ? '1 : acc_sum[1][47:0];
        mem_wd.sum_b = acc_sum[2][48] ? '1 : acc_sum[2][47:0];
        mem_wd.sum_w = acc_w[40] ? '1 : acc_w[39:0];
        if (cmd.clear)
        begin
            mem_wd = '0;
        end
        mem_we = cmd.clear || (cmd.fetch && (req_reg == REQ_ACC));
        mem_wa = cmd.clear ? clr_reg : addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.check)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.fetch)
        begin
            step_reg <= 5'(Q_W - 1);
        end
        else if (cmd.div && (step_reg == '0))
        begin
            step_reg <= 5'd7;
        end
        else if (cmd.div || cmd.enc)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_comb
    begin
        div_sh = DIVSH_W'(div_reg) << step_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (wz_reg)
            begin
                v[i] = '0;
            end
            else if (ov_reg[i])
            begin
                v[i] = Q_W'(65536);
            end
            else
            begin
                v[i] = (q_reg[i] > Q_W'(65536)) ? Q_W'(65536) : q_reg[i];
            end
            idx_full[i] = ((Q_W + LUT_BITS)'(v[i]) << LUT_BITS) >> 16;
            idx[i]      = (idx_full[i] > (Q_W + LUT_BITS)'(LUT_SIZE)) ? IDX_W'(LUT_SIZE)
                                                                     : IDX_W'(idx_full[i]);
            trial[i]    = code_reg[i] | (8'd1 << step_reg[2:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            div_reg <= rd_reg.sum_w;
            wz_reg  <= (rd_reg.sum_w == '0);
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i]  <= sum_in[i];
                q_reg[i]    <= '0;
                ov_reg[i]   <= DIVSH_W'(sum_in[i]) >= (DIVSH_W'(rd_reg.sum_w) << Q_W);
                code_reg[i] <= '0;
            end
        end
        else if (cmd.div)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (DIVSH_W'(rem_reg[i]) >= div_sh)
                begin
                    rem_reg[i]                 <= rem_reg[i] - div_sh[47:0];
                    q_reg[i][step_reg[4:0]]    <= 1'b1;
                end
            end
        end
        else if (cmd.enc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (CODE_THR[trial[i]] <= idx[i])
                begin
                    code_reg[i] <= trial[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check && drop)
        begin
            status_reg <= STAT_DROP;
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= '0;
            end
        end
        else if (cmd.fetch && (req_reg == REQ_ACC))
        begin
            status_reg <= STAT_ACC;
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= '0;
            end
        end
        else if (cmd.enc && (step_reg == '0))
        begin
            status_reg <= STAT_READ;
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= (CODE_THR[trial[i]] <= idx[i]) ? trial[i] : code_reg[i];
            end
        end
    end

    assign dp_stat.drop      = drop;
    assign dp_stat.is_read   = (req_reg == REQ_READ);
    assign dp_stat.clr_last  = (clr_reg == '1);
    assign dp_stat.step_last = (step_reg == '0);

    assign status     = status_reg;
    assign srgb_red   = out_reg[0];
    assign srgb_green = out_reg[1];
    assign srgb_blue  = out_reg[2];

endmodule

// File: rtl/weighted_tile_blend_accumulator.sv
// Top level of the weighted tile blend accumulator with sRGB encode.
// After reset the block clears its 65536-entry pixel store, one entry per cycle, and holds
// busy high until the clear ends; configuration writes are taken meanwhile. A request is
// taken when start is high and busy is low; busy stays high until it is done. A dropped
// request skips to the result, an accumulate does a store read, then a read-modify-write,
// and a read does a store read, the one-bit-per-cycle divider, then the binary search in
// the sRGB threshold table. The result appears for exactly one cycle with done high; the
// receiver cannot stall it, so it must take every result in that cycle.
`include "assert_macros.svh"

module weighted_tile_blend_accumulator
    import wtba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [8:0]        cfg_wdata,
    input  logic              req_type,
    input  logic [7:0]        pos_x,
    input  logic [7:0]        pos_y,
    input  logic signed [8:0] origin_x,
    input  logic signed [8:0] origin_y,
    input  logic [8:0]        tile_width,
    input  logic [8:0]        tile_height,
    input  logic [16:0]       blend_weight,
    input  logic [16:0]       lin_red,
    input  logic [16:0]       lin_green,
    input  logic [16:0]       lin_blue,
    output logic [1:0]        status,
    output logic [7:0]        srgb_red,
    output logic [7:0]        srgb_green,
    output logic [7:0]        srgb_blue
);

    cmd_t     cmd;
    dp_stat_t dp_stat;

    wtba_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    wtba_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .req_type     (req_type),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .tile_width   (tile_width),
        .tile_height  (tile_height),
        .blend_weight (blend_weight),
        .lin_red      (lin_red),
        .lin_green    (lin_green),
        .lin_blue     (lin_blue),
        .status       (status),
        .srgb_red     (srgb_red),
        .srgb_green   (srgb_green),
        .srgb_blue    (srgb_blue)
    );

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted request not busy")
    `ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
    `ASSERT_IMPL(a_done_busy, done, busy, "result while idle")
    `ASSERT_IMPL(a_zero_codes, done && (status != STAT_READ),
                 (srgb_red == 8'd0) && (srgb_green == 8'd0) && (srgb_blue == 8'd0),
                 "nonzero codes on a non-read result")

endmodule
